// ----- rtl/lfrd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfrd_pkg
// Shared types, codes and sizes for the link frame receiver with byte
// destuffing: configuration set, frame phases, control codes, result word.
// ----------------------------------------------------------------------------
package lfrd_pkg;

  // Payload storage capacity and derived widths
  localparam int unsigned PayloadCapacity = 1024;
  localparam int unsigned CntW            = $clog2(PayloadCapacity + 1);
  localparam int unsigned DidxW           = 10;
  localparam int unsigned SizeW           = 11;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned InDataW         = 8;
  localparam int unsigned OutDataW        = 56;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG_BYTE   = 3'd0,
    CFG_ESCAPE_BYTE = 3'd1,
    CFG_ESCAPE_MASK = 3'd2,
    CFG_SENDER_ADDR = 3'd3,
    CFG_RECVR_ADDR  = 3'd4
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [7:0] FlagByteRst   = 8'd126;
  localparam logic [7:0] EscapeByteRst = 8'd125;
  localparam logic [7:0] EscapeMaskRst = 8'd32;
  localparam logic [7:0] SenderAddrRst = 8'd3;
  localparam logic [7:0] RecvrAddrRst  = 8'd1;

  // Frame control codes
  localparam logic [7:0] CtlSet  = 8'h03;
  localparam logic [7:0] CtlUa   = 8'h07;
  localparam logic [7:0] CtlDisc = 8'h0B;
  localparam logic [7:0] CtlRr0  = 8'h05;
  localparam logic [7:0] CtlRr1  = 8'h85;
  localparam logic [7:0] CtlRej0 = 8'h01;
  localparam logic [7:0] CtlRej1 = 8'h81;
  localparam logic [7:0] CtlI0   = 8'h00;
  localparam logic [7:0] CtlI1   = 8'h40;

  // Receiver phase, one-hot
  typedef enum logic [12:0] {
    PH_HUNT = 13'b0000000000001,
    PH_FLAG = 13'b0000000000010,
    PH_ADDR = 13'b0000000000100,
    PH_CTRL = 13'b0000000001000,
    PH_HDR  = 13'b0000000010000,
    PH_DATA = 13'b0000000100000,
    PH_SET  = 13'b0000001000000,
    PH_UA   = 13'b0000010000000,
    PH_DISC = 13'b0000100000000,
    PH_RR0  = 13'b0001000000000,
    PH_RR1  = 13'b0010000000000,
    PH_REJ0 = 13'b0100000000000,
    PH_REJ1 = 13'b1000000000000
  } phase_e;

  // Phase as reported on the result word
  typedef enum logic [3:0] {
    PC_HUNT = 4'd0,
    PC_FLAG = 4'd1,
    PC_ADDR = 4'd2,
    PC_CTRL = 4'd3,
    PC_HDR  = 4'd4,
    PC_DATA = 4'd5,
    PC_SET  = 4'd6,
    PC_UA   = 4'd7,
    PC_DISC = 4'd8,
    PC_RR0  = 4'd9,
    PC_RR1  = 4'd10,
    PC_REJ0 = 4'd11,
    PC_REJ1 = 4'd12
  } phase_code_e;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
    logic [7:0] sender_address;
    logic [7:0] receiver_address;
  } cfg_t;

  // Result word, phase_code in the lowest bits
  typedef struct packed {
    logic             overflow;
    logic             halted_error;
    logic [SizeW-1:0] payload_size;
    logic [DidxW-1:0] data_index;
    logic [7:0]       data_byte;
    logic             data_valid;
    logic [7:0]       frame_control;
    logic [7:0]       frame_address;
    phase_code_e      phase_code;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

  function automatic phase_code_e phase_code_of(phase_e ph);
    phase_code_e pc;
    unique case (ph)
      PH_HUNT: pc = PC_HUNT;
      PH_FLAG: pc = PC_FLAG;
      PH_ADDR: pc = PC_ADDR;
      PH_CTRL: pc = PC_CTRL;
      PH_HDR:  pc = PC_HDR;
      PH_DATA: pc = PC_DATA;
      PH_SET:  pc = PC_SET;
      PH_UA:   pc = PC_UA;
      PH_DISC: pc = PC_DISC;
      PH_RR0:  pc = PC_RR0;
      PH_RR1:  pc = PC_RR1;
      PH_REJ0: pc = PC_REJ0;
      PH_REJ1: pc = PC_REJ1;
      default: pc = PC_HUNT;
    endcase
    return pc;
  endfunction

endpackage

// ----- rtl/link_frame_receiver_destuff.sv -----
// ----------------------------------------------------------------------------
// link_frame_receiver_destuff
// HDLC-style frame receiver: one line word in, one status/result word out.
// Path: an accepted input word waits in the input register; its result is
// registered in the result register as soon as that slot is free.
// Throughput: one word per cycle while the master side does not stall; the
// frame step is one combinational pass between the input and result registers.
// Reset: asynchronous, active low; hunts for a flag with all frame state cleared
// and configuration at its defaults.
// ----------------------------------------------------------------------------
module link_frame_receiver_destuff (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  // input words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lfrd_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]                    s_axis_tuser,  // [0] func (1 = rearm)
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] phase_code, [11:4] frame_address, [19:12] frame_control,
  // [20] data_valid, [28:21] data_byte, [38:29] data_index,
  // [49:39] payload_size, [50] halted_error, [51] overflow, [55:52] zero
  output logic [lfrd_pkg::OutDataW-1:0] m_axis_tdata
);
  import lfrd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_res_q;
  logic       advance;

  lfrd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move a word from the input register once the result slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  lfrd_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .rearm_i   (in_func_q),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata[7:0];
    end
  end

  // Result register; hold while the master side stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ResW)'(0), out_res_q};

endmodule

// ----- rtl/lfrd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lfrd_cfg_regs
// Configuration register file: flag, escape, mask and the two addresses.
// ----------------------------------------------------------------------------
module lfrd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfrd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  output lfrd_pkg::cfg_t               cfg_o
);
  import lfrd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index; unknown indexes write nothing
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLAG_BYTE:   cfg_d.flag_byte        = cfg_data_i;
        CFG_ESCAPE_BYTE: cfg_d.escape_byte      = cfg_data_i;
        CFG_ESCAPE_MASK: cfg_d.escape_mask      = cfg_data_i;
        CFG_SENDER_ADDR: cfg_d.sender_address   = cfg_data_i;
        CFG_RECVR_ADDR:  cfg_d.receiver_address = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte        <= FlagByteRst;
      cfg_q.escape_byte      <= EscapeByteRst;
      cfg_q.escape_mask      <= EscapeMaskRst;
      cfg_q.sender_address   <= SenderAddrRst;
      cfg_q.receiver_address <= RecvrAddrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/lfrd_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// lfrd_frame_fsm
// Frame state and one-word step: header check, destuffing with a one-word
// delay, trailer check and sticky outcome phases.
// ----------------------------------------------------------------------------
module lfrd_frame_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lfrd_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  logic           rearm_i,
  input  logic [7:0]     rx_byte_i,
  output lfrd_pkg::res_t res_o
);
  import lfrd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [7:0]        check_q, check_d;
  logic [7:0]        pend_q, pend_d;
  logic              esc_q, esc_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SizeW-1:0]  size_q, size_d;

  logic is_flag;
  logic known_ctrl;
  logic is_iframe;

  assign is_flag    = (rx_byte_i == cfg_i.flag_byte);
  assign is_iframe  = (ctrl_q == CtlI0) || (ctrl_q == CtlI1);
  assign known_ctrl = (rx_byte_i == CtlSet)  || (rx_byte_i == CtlUa)   ||
                      (rx_byte_i == CtlDisc) || (rx_byte_i == CtlRr0)  ||
                      (rx_byte_i == CtlRr1)  || (rx_byte_i == CtlRej0) ||
                      (rx_byte_i == CtlRej1) || (rx_byte_i == CtlI0)   ||
                      (rx_byte_i == CtlI1);

  // Next state and result for one word
  always_comb begin
    phase_d = phase_q;
    addr_d  = addr_q;
    ctrl_d  = ctrl_q;
    check_d = check_q;
    pend_d  = pend_q;
    esc_d   = esc_q;
    count_d = count_q;
    size_d  = size_q;

    res_o.data_valid   = 1'b0;
    res_o.data_byte    = '0;
    res_o.data_index   = '0;
    res_o.halted_error = 1'b0;
    res_o.overflow     = 1'b0;

    if (rearm_i) begin
      phase_d = PH_HUNT;
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (is_flag) phase_d = PH_FLAG;
        end
        PH_FLAG: begin
          if (!is_flag) begin
            if (rx_byte_i == cfg_i.sender_address ||
                rx_byte_i == cfg_i.receiver_address) begin
              addr_d  = rx_byte_i;
              phase_d = PH_ADDR;
            end else begin
              phase_d = PH_HUNT;
            end
          end
        end
        PH_ADDR: begin
          if (is_flag) begin
            phase_d = PH_FLAG;
          end else if (known_ctrl) begin
            ctrl_d  = rx_byte_i;
            phase_d = PH_CTRL;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_CTRL: begin
          if (is_flag)                           phase_d = PH_FLAG;
          else if ((addr_q ^ ctrl_q) == rx_byte_i) phase_d = PH_HDR;
          else                                   phase_d = PH_HUNT;
        end
        PH_HDR: begin
          if (is_flag && ctrl_q == CtlSet)       phase_d = PH_SET;
          else if (is_flag && ctrl_q == CtlUa)   phase_d = PH_UA;
          else if (is_flag && ctrl_q == CtlDisc) phase_d = PH_DISC;
          else if (is_flag && ctrl_q == CtlRr0)  phase_d = PH_RR0;
          else if (is_flag && ctrl_q == CtlRr1)  phase_d = PH_RR1;
          else if (is_flag && ctrl_q == CtlRej0) phase_d = PH_REJ0;
          else if (is_flag && ctrl_q == CtlRej1) phase_d = PH_REJ1;
          else if (is_iframe) begin
            // Open the payload: first word goes pending, even a flag
            check_d = '0;
            pend_d  = rx_byte_i;
            count_d = '0;
            size_d  = '0;
            esc_d   = 1'b0;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (is_flag) begin
            // Close the frame on the trailer check
            if (check_q == pend_q) begin
              size_d  = SizeW'(count_q);
              phase_d = (ctrl_q == CtlI0) ? PH_RR1 : PH_RR0;
            end else begin
              phase_d = (ctrl_q == CtlI0) ? PH_REJ0 : PH_REJ1;
            end
          end else if (pend_q == cfg_i.escape_byte && !esc_q) begin
            // Replace the escape by the unstuffed word
            esc_d  = 1'b1;
            pend_d = rx_byte_i ^ cfg_i.escape_mask;
          end else begin
            check_d = check_q ^ pend_q;
            if (count_q < CntW'(PayloadCapacity)) begin
              res_o.data_valid = 1'b1;
              res_o.data_byte  = pend_q;
              res_o.data_index = DidxW'(count_q);
              count_d          = count_q + 1'b1;
            end else begin
              res_o.overflow = 1'b1;
            end
            pend_d = rx_byte_i;
            esc_d  = 1'b0;
          end
        end
        PH_SET, PH_UA, PH_DISC, PH_RR0, PH_RR1, PH_REJ0, PH_REJ1: begin
          res_o.halted_error = 1'b1;
        end
        default: begin
          res_o.halted_error = 1'b1;
        end
      endcase
    end

    res_o.phase_code    = phase_code_of(phase_d);
    res_o.frame_address = addr_d;
    res_o.frame_control = ctrl_d;
    res_o.payload_size  = size_d;
  end

  // Advance the frame state once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      addr_q  <= '0;
      ctrl_q  <= '0;
      check_q <= '0;
      pend_q  <= '0;
      esc_q   <= 1'b0;
      count_q <= '0;
      size_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      ctrl_q  <= ctrl_d;
      check_q <= check_d;
      pend_q  <= pend_d;
      esc_q   <= esc_d;
      count_q <= count_d;
      size_q  <= size_d;
    end
  end

  // An emitted data word bumps the count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.data_valid |=> count_q == $past(count_q) + 1'b1)
    else $error("payload count did not advance on emitted word");

  // Overflow only once the count has reached capacity
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.overflow |-> count_q == CntW'(PayloadCapacity))
    else $error("overflow below capacity");

  // Rearm always lands in hunting
  a_rearm_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rearm_i |=> phase_q == PH_HUNT)
    else $error("rearm did not return to hunting");

  // Only a halted phase flags an error, and then emits nothing
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.halted_error |-> !res_o.data_valid && !res_o.overflow &&
      (phase_d == phase_q))
    else $error("halted word changed the frame");

endmodule

// ----- bench/tb_link_frame_receiver_destuff.sv -----
// ----------------------------------------------------------------------------
// tb_link_frame_receiver_destuff
// Self-checking bench for the HDLC-style frame receiver with byte destuffing.
// A queue of line words feeds a clocked driver; a clocked monitor compares
// every result word with a behavioral receiver run at input acceptance.
// Traffic is mostly well-formed frames (supervisory and information, with
// stuffed payload) mixed with broken frames and noise, under several
// register settings, with random idling on both sides and two long output holds.
// ----------------------------------------------------------------------------
module tb_link_frame_receiver_destuff;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrd_pkg::*;

  // One line word: rearm flag and received byte
  typedef struct packed {
    logic       rearm;
    logic [7:0] rx;
  } line_word_t;

  localparam int unsigned HoldLen   = 300;
  localparam int unsigned HoldAt0   = 300;
  localparam int unsigned HoldAt1   = 1200;
  localparam int unsigned CalmStart = 1500;
  localparam int unsigned CalmStop  = 2500;
  localparam int unsigned PhaseLen  = 80;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [7:0]           cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;  // [7:0] rx_byte
  logic [0:0]           s_axis_tuser  = '0;  // [0] func (1 = rearm)
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [3:0] phase_code, [11:4] frame_address, [19:12] frame_control,
  // [20] data_valid, [28:21] data_byte, [38:29] data_index,
  // [49:39] payload_size, [50] halted_error, [51] overflow
  logic [OutDataW-1:0]  m_axis_tdata;

  link_frame_receiver_destuff u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle count, used for the calm window and the output hold
  int unsigned cyc = 0;
  always @(posedge clk_i) cyc <= cyc + 1;

  wire calm = (cyc >= CalmStart) && (cyc < CalmStop);

  // Behavioral receiver: register copy and frame state
  cfg_t        line_cfg;
  phase_code_e fr_phase   = PC_HUNT;
  logic [7:0]  fr_addr    = '0;
  logic [7:0]  fr_ctrl    = '0;
  logic [7:0]  fr_check   = '0;
  logic [7:0]  fr_pending = '0;
  logic        fr_esc     = 1'b0;
  logic [10:0] fr_count   = '0;
  logic [10:0] fr_size    = '0;

  line_word_t line_words[$];   // words waiting for the driver
  line_word_t frame_buf[$];    // words being built for one phase
  res_t       status_due[$];   // result words still to come
  line_word_t next_word;
  res_t       seen_word;
  res_t       due_word;
  int         mismatches = 0;
  int unsigned hold_left = 0;

  // Advance the receiver by one line word and return the status it reports
  function automatic res_t advance_receiver(input logic rearm, input logic [7:0] b);
    res_t r;
    logic is_flag;
    logic seq0;
    r       = '0;
    is_flag = (b == line_cfg.flag_byte);
    seq0    = (fr_ctrl == CtlI0);
    if (rearm) begin
      fr_phase = PC_HUNT;
    end else begin
      case (fr_phase)
        PC_HUNT: begin
          if (is_flag) fr_phase = PC_FLAG;
        end
        PC_FLAG: begin
          if (!is_flag) begin
            if (b == line_cfg.sender_address || b == line_cfg.receiver_address) begin
              fr_addr  = b;
              fr_phase = PC_ADDR;
            end else begin
              fr_phase = PC_HUNT;
            end
          end
        end
        PC_ADDR: begin
          if (is_flag) begin
            fr_phase = PC_FLAG;
          end else if (b == CtlSet || b == CtlUa || b == CtlDisc || b == CtlRr0 ||
                       b == CtlRr1 || b == CtlRej0 || b == CtlRej1 || b == CtlI0 ||
                       b == CtlI1) begin
            fr_ctrl  = b;
            fr_phase = PC_CTRL;
          end else begin
            fr_phase = PC_HUNT;
          end
        end
        PC_CTRL: begin
          if (is_flag) fr_phase = PC_FLAG;
          else if ((fr_addr ^ fr_ctrl) == b) fr_phase = PC_HDR;
          else fr_phase = PC_HUNT;
        end
        PC_HDR: begin
          if (fr_ctrl == CtlI0 || fr_ctrl == CtlI1) begin
            // Frame start: the next byte is pending even if it is a flag
            fr_check   = '0;
            fr_pending = b;
            fr_count   = '0;
            fr_size    = '0;
            fr_esc     = 1'b0;
            fr_phase   = PC_DATA;
          end else if (!is_flag) begin
            fr_phase = PC_HUNT;
          end else begin
            case (fr_ctrl)
              CtlSet:  fr_phase = PC_SET;
              CtlUa:   fr_phase = PC_UA;
              CtlDisc: fr_phase = PC_DISC;
              CtlRr0:  fr_phase = PC_RR0;
              CtlRr1:  fr_phase = PC_RR1;
              CtlRej0: fr_phase = PC_REJ0;
              CtlRej1: fr_phase = PC_REJ1;
              default: fr_phase = PC_HUNT;
            endcase
          end
        end
        PC_DATA: begin
          if (is_flag) begin
            // Closing flag: trailer check decides acknowledge or reject
            if (fr_check == fr_pending) begin
              fr_size  = fr_count;
              fr_phase = seq0 ? PC_RR1 : PC_RR0;
            end else begin
              fr_phase = seq0 ? PC_REJ0 : PC_REJ1;
            end
          end else if (fr_pending == line_cfg.escape_byte && !fr_esc) begin
            fr_esc     = 1'b1;
            fr_pending = b ^ line_cfg.escape_mask;
          end else begin
            fr_check = fr_check ^ fr_pending;
            if (fr_count < PayloadCapacity) begin
              r.data_valid = 1'b1;
              r.data_byte  = fr_pending;
              r.data_index = fr_count[DidxW-1:0];
              fr_count     = fr_count + 11'd1;
            end else begin
              r.overflow = 1'b1;
            end
            fr_pending = b;
            fr_esc     = 1'b0;
          end
        end
        default: begin
          r.halted_error = 1'b1;
        end
      endcase
    end
    r.phase_code    = fr_phase;
    r.frame_address = fr_addr;
    r.frame_control = fr_ctrl;
    r.payload_size  = fr_size;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: record accepted words, then offer the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        status_due.push_back(advance_receiver(s_axis_tuser[0], s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (line_words.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          next_word = line_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.rx;
          s_axis_tuser  <= next_word.rearm;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word, and stall at random or for a long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_word = m_axis_tdata[ResW-1:0];
        if (status_due.size() == 0) begin
          $display("%0t mismatch word: expected none actual %0h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          due_word = status_due.pop_front();
          check_field("phase_code", due_word.phase_code, seen_word.phase_code);
          check_field("frame_address", due_word.frame_address, seen_word.frame_address);
          check_field("frame_control", due_word.frame_control, seen_word.frame_control);
          check_field("data_valid", due_word.data_valid, seen_word.data_valid);
          check_field("data_byte", due_word.data_byte, seen_word.data_byte);
          check_field("data_index", due_word.data_index, seen_word.data_index);
          check_field("payload_size", due_word.payload_size, seen_word.payload_size);
          check_field("halted_error", due_word.halted_error, seen_word.halted_error);
          check_field("overflow", due_word.overflow, seen_word.overflow);
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (cyc == HoldAt0 || cyc == HoldAt1) begin
        hold_left     <= HoldLen;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  task automatic push_word(input logic rearm, input logic [7:0] b);
    line_word_t w;
    w.rearm = rearm;
    w.rx    = b;
    frame_buf.push_back(w);
  endtask

  // Send a payload byte, stuffed when it is a flag or an escape
  task automatic push_stuffed(input logic [7:0] b);
    if (b == line_cfg.flag_byte || b == line_cfg.escape_byte) begin
      push_word(1'b0, line_cfg.escape_byte);
      push_word(1'b0, b ^ line_cfg.escape_mask);
    end else begin
      push_word(1'b0, b);
    end
  endtask

  // Payload byte, often a special one, never one that cannot be stuffed
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = line_cfg.flag_byte;
      1:       b = line_cfg.escape_byte;
      default: b = 8'($urandom);
    endcase
    while ((b == line_cfg.flag_byte || b == line_cfg.escape_byte) &&
           ((b ^ line_cfg.escape_mask) == line_cfg.flag_byte))
      b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] known_control(input bit info_only);
    logic [7:0] c;
    case (info_only ? $urandom_range(7, 8) : $urandom_range(0, 8))
      0:       c = CtlSet;
      1:       c = CtlUa;
      2:       c = CtlDisc;
      3:       c = CtlRr0;
      4:       c = CtlRr1;
      5:       c = CtlRej0;
      6:       c = CtlRej1;
      7:       c = CtlI0;
      default: c = CtlI1;
    endcase
    return c;
  endfunction

  function automatic int unsigned payload_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
  endfunction

  // Build one whole frame; information frames carry payload and trailer
  task automatic push_frame(input logic [7:0] ctl, input int unsigned len,
                            input bit bad_check);
    logic [7:0] addr;
    logic [7:0] chk;
    logic [7:0] b;
    addr = $urandom_range(0, 1) ? line_cfg.sender_address : line_cfg.receiver_address;
    chk  = '0;
    push_word(1'b0, line_cfg.flag_byte);
    push_word(1'b0, addr);
    push_word(1'b0, ctl);
    push_word(1'b0, addr ^ ctl);
    if (ctl == CtlI0 || ctl == CtlI1) begin
      for (int i = 0; i < len; i++) begin
        b   = payload_byte();
        chk = chk ^ b;
        push_stuffed(b);
      end
      if (bad_check) chk = chk ^ (8'h01 << $urandom_range(0, 7));
      push_stuffed(chk);
    end
    push_word(1'b0, line_cfg.flag_byte);
  endtask

  // Random traffic: good frames, rejected frames, broken frames and noise
  task automatic push_traffic(input int unsigned budget);
    int unsigned pick;
    int unsigned start;
    int unsigned k;
    line_word_t  w;
    logic [7:0]  ctl;
    while (frame_buf.size() < budget) begin
      pick  = $urandom_range(0, 99);
      start = frame_buf.size();
      if (pick < 45) begin
        push_frame(known_control(1), payload_len(), 0);
      end else if (pick < 55) begin
        push_frame(known_control(1), payload_len(), 1);
      end else if (pick < 75) begin
        push_frame(known_control(0), 0, 0);
      end else if (pick < 87) begin
        ctl = ($urandom_range(0, 2) == 0) ? 8'($urandom) : known_control(0);
        push_frame(ctl, payload_len(), 0);
        if ($urandom_range(0, 1)) begin
          k = $urandom_range(start + 1, frame_buf.size() - 1);
          w = frame_buf[k];
          w.rx = 8'($urandom);
          frame_buf[k] = w;
        end else begin
          repeat ($urandom_range(1, frame_buf.size() - start - 1))
            void'(frame_buf.pop_back());
        end
      end else begin
        repeat ($urandom_range(1, 6))
          push_word($urandom_range(0, 3) == 0, 8'($urandom));
      end
      // Stray bytes in the outcome phase, then rearm
      repeat ($urandom_range(0, 2)) push_word(1'b0, 8'($urandom));
      push_word(1'b1, 8'($urandom));
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FLAG_BYTE:   line_cfg.flag_byte        = val;
      CFG_ESCAPE_BYTE: line_cfg.escape_byte      = val;
      CFG_ESCAPE_MASK: line_cfg.escape_mask      = val;
      CFG_SENDER_ADDR: line_cfg.sender_address   = val;
      CFG_RECVR_ADDR:  line_cfg.receiver_address = val;
      default: ;
    endcase
  endtask

  task automatic write_line_cfg(input logic [7:0] f, input logic [7:0] e,
                                input logic [7:0] m, input logic [7:0] s,
                                input logic [7:0] r);
    write_reg(CFG_FLAG_BYTE, f);
    write_reg(CFG_ESCAPE_BYTE, e);
    write_reg(CFG_ESCAPE_MASK, m);
    write_reg(CFG_SENDER_ADDR, s);
    write_reg(CFG_RECVR_ADDR, r);
  endtask

  // Hand the built words to the driver and wait until every result is back
  task automatic run_and_settle();
    foreach (frame_buf[k]) line_words.push_back(frame_buf[k]);
    frame_buf.delete();
    while (line_words.size() != 0 || s_axis_tvalid || status_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] f;
    logic [7:0] e;
    logic [7:0] m;
    logic [7:0] s;
    logic [7:0] r;
    line_cfg = {FlagByteRst, EscapeByteRst, EscapeMaskRst, SenderAddrRst, RecvrAddrRst};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: write_line_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
        2: write_line_cfg(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        3: write_line_cfg(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFE);
        4: write_line_cfg(FlagByteRst, EscapeByteRst, EscapeMaskRst, SenderAddrRst,
                          RecvrAddrRst);
        default: ;
      endcase
      if (p == 0) begin
        f = line_cfg.flag_byte;
        e = line_cfg.escape_byte;
        m = line_cfg.escape_mask;
        s = line_cfg.sender_address;
        r = line_cfg.receiver_address;
        // Hunt ignores extremes; repeated flags in flag and address phases
        push_word(1'b0, 8'h00);
        push_word(1'b0, 8'hFF);
        push_word(1'b0, f);
        push_word(1'b0, f);
        push_word(1'b0, s);
        push_word(1'b0, f);
        push_word(1'b0, r);
        push_word(1'b0, CtlI1);
        push_word(1'b0, r ^ CtlI1);
        // Flag right after the header is the first pending byte
        push_word(1'b0, f);
        // Stuffed escape, then trailer over both data bytes
        push_word(1'b0, e);
        push_word(1'b0, e ^ m);
        push_word(1'b0, f ^ e);
        push_word(1'b0, f);
        // Byte in the outcome phase, then rearm
        push_word(1'b0, 8'hFF);
        push_word(1'b1, 8'hFF);
        // Unknown address, then bad header check
        push_word(1'b0, f);
        push_word(1'b0, 8'h22);
        push_word(1'b0, f);
        push_word(1'b0, s);
        push_word(1'b0, CtlSet);
        push_word(1'b0, 8'h11);
        // One frame past payload capacity
        push_frame(CtlI0, PayloadCapacity + 2, 0);
        push_word(1'b1, 8'h00);
      end
      push_traffic(frame_buf.size() + PhaseLen);
      run_and_settle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_link_frame_receiver_destuff: clean");
    end else begin
      $display("tb_link_frame_receiver_destuff: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("tb_link_frame_receiver_destuff: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lfrd_pkg.sv
rtl/lfrd_cfg_regs.sv
rtl/lfrd_frame_fsm.sv
rtl/link_frame_receiver_destuff.sv
bench/tb_link_frame_receiver_destuff.sv
